>>> hdl/uvs_pkg.sv
`timescale 1ns / 1ps
package uvs_pkg;

  localparam int MAX_PRECISION = 256;
  localparam int ANGLE_BITS    = 16;

  // divider geometry: quotient bits, numerator and denominator widths
  localparam int DIV_QBITS  = ANGLE_BITS + 1;
  localparam int DIV_NBITS  = ANGLE_BITS + 10;
  localparam int DIV_DBITS  = 11;
  localparam int DIV_STAGES = (DIV_QBITS + 1) / 2;

  localparam int SIN_STAGES = 6;

  // pipeline stage map
  localparam int ST_IN   = 0;
  localparam int ST_DIVA = ST_IN + 1;
  localparam int ST_DEC1 = ST_DIVA + DIV_STAGES;
  localparam int ST_DEC2 = ST_DEC1 + 1;
  localparam int ST_DIVB = ST_DEC2 + 1;
  localparam int ST_SIN  = ST_DIVB + DIV_STAGES;
  localparam int ST_NRM  = ST_SIN + SIN_STAGES;
  localparam int ST_POS  = ST_NRM + 1;
  localparam int NS      = ST_POS + 1;

  // sine polynomial coefficients, Q30
  localparam logic [30:0] C1 = 31'd1686629713;
  localparam logic [30:0] C3 = 31'd693598668;
  localparam logic [30:0] C5 = 31'd85569306;
  localparam logic [30:0] C7 = 31'd5026995;
  localparam logic [30:0] C9 = 31'd172272;

  // reciprocal of six, scaled by 2^18
  localparam logic [15:0] RECIP6 = 16'd43691;

  // register indexes
  localparam logic [1:0] REG_PRECISION = 2'd0;
  localparam logic [1:0] REG_RADIUS    = 2'd1;
  localparam logic [1:0] REG_COLOR     = 2'd2;

  typedef logic [ANGLE_BITS-1:0] angle_t;

  typedef struct packed {
    logic [8:0]  p;
    logic [10:0] per;
    logic [18:0] total;
    logic [15:0] radius;
    logic [31:0] color;
  } cfg_t;

  typedef struct packed {
    logic oor;
    logic fin;
    logic pole;
    logic pole_top;
    logic th_neg;
  } meta_t;

  // signed q1.14 product, magnitude rounded half up
  function automatic logic signed [15:0] mul_round14(input logic signed [15:0] a,
                                                     input logic signed [15:0] b);
    logic [15:0] ma;
    logic [15:0] mb;
    logic [32:0] p;
    logic [15:0] m;
    ma = a[15] ? 16'(-a) : 16'(a);
    mb = b[15] ? 16'(-b) : 16'(b);
    p  = 33'(ma * mb) + 33'd8192;
    m  = p[29:14];
    mul_round14 = (a[15] ^ b[15]) ? -$signed(m) : $signed(m);
  endfunction

  // q1.14 times unsigned q8.8 radius, giving signed q8.8
  function automatic logic signed [16:0] mul_pos(input logic signed [15:0] n,
                                                 input logic [15:0] r);
    logic [15:0] mn;
    logic [32:0] p;
    logic [16:0] m;
    mn = n[15] ? 16'(-n) : 16'(n);
    p  = 33'(mn * r) + 33'd8192;
    m  = p[30:14];
    mul_pos = n[15] ? -$signed(m) : $signed(m);
  endfunction

endpackage

>>> hdl/uvs_cfg.sv
`timescale 1ns / 1ps
module uvs_cfg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output uvs_pkg::cfg_t       cfg
);
  import uvs_pkg::*;

  logic [8:0]  prec_r;
  logic [15:0] radius_r;
  logic [31:0] color_r;
  logic [8:0]  p_clamp;
  logic [10:0] per;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prec_r   <= 9'd16;
      radius_r <= 16'd256;
      color_r  <= 32'hFFFF_FFFF;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_PRECISION: prec_r   <= pwdata[8:0];
        REG_RADIUS:    radius_r <= pwdata[15:0];
        REG_COLOR:     color_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (paddr[3:2])
      REG_PRECISION: prdata = {23'd0, prec_r};
      REG_RADIUS:    prdata = {16'd0, radius_r};
      REG_COLOR:     prdata = color_r;
      default:       prdata = 32'd0;
    endcase
  end

  // clamped precision and list sizes
  always_comb begin
    if (prec_r < 9'd2) p_clamp = 9'd2;
    else if (32'(prec_r) > MAX_PRECISION) p_clamp = 9'(MAX_PRECISION);
    else p_clamp = prec_r;
    per = 11'(11'(p_clamp) * 11'd6 - 11'd6);
  end

  assign cfg.p      = p_clamp;
  assign cfg.per    = per;
  assign cfg.total  = 19'(19'(p_clamp) * 19'(per));
  assign cfg.radius = radius_r;
  assign cfg.color  = color_r;

endmodule

>>> hdl/uvs_div.sv
`timescale 1ns / 1ps
module uvs_div (
  input  logic                              clk,
  input  logic [uvs_pkg::DIV_STAGES-1:0]    ld,
  input  logic [uvs_pkg::DIV_NBITS-1:0]     num,
  input  logic [uvs_pkg::DIV_DBITS-1:0]     den,
  output logic [uvs_pkg::DIV_QBITS-1:0]     quo,
  output logic [uvs_pkg::DIV_DBITS-1:0]     rem
);
  import uvs_pkg::*;

  localparam int HB = DIV_NBITS - DIV_QBITS;

  logic [DIV_DBITS-1:0] rem_r [DIV_STAGES];
  logic [DIV_QBITS-1:0] quo_r [DIV_STAGES];
  logic [DIV_QBITS-1:0] num_r [DIV_STAGES];
  logic [DIV_DBITS-1:0] den_r [DIV_STAGES];

  // restoring division, two quotient bits per stage
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
    logic [DIV_DBITS-1:0] r_i;
    logic [DIV_QBITS-1:0] q_i;
    logic [DIV_QBITS-1:0] n_i;
    logic [DIV_DBITS-1:0] d_i;
    logic [DIV_DBITS-1:0] rem_nxt;
    logic [DIV_QBITS-1:0] quo_nxt;

    if (s == 0) begin : g_first
      assign r_i = DIV_DBITS'(num[DIV_NBITS-1:DIV_QBITS]);
      assign q_i = '0;
      assign n_i = num[DIV_QBITS-1:0];
      assign d_i = den;
    end else begin : g_next
      assign r_i = rem_r[s-1];
      assign q_i = quo_r[s-1];
      assign n_i = num_r[s-1];
      assign d_i = den_r[s-1];
    end

    always_comb begin
      logic [DIV_DBITS:0] t;
      int bi;
      rem_nxt = r_i;
      quo_nxt = q_i;
      for (int j = 0; j < 2; j++) begin
        bi = DIV_QBITS - 1 - 2 * s - j;
        if (bi >= 0) begin
          t = {rem_nxt, n_i[bi]};
          if (t >= {1'b0, d_i}) begin
            rem_nxt = DIV_DBITS'(t - {1'b0, d_i});
            quo_nxt = {quo_nxt[DIV_QBITS-2:0], 1'b1};
          end else begin
            rem_nxt = t[DIV_DBITS-1:0];
            quo_nxt = {quo_nxt[DIV_QBITS-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (ld[s]) begin
        rem_r[s] <= rem_nxt;
        quo_r[s] <= quo_nxt;
        num_r[s] <= n_i;
        den_r[s] <= d_i;
      end
    end
  end

  assign quo = quo_r[DIV_STAGES-1];
  assign rem = rem_r[DIV_STAGES-1];

  // top numerator bits only seed the remainder
  logic unused_hb;
  assign unused_hb = ^HB;

endmodule

>>> hdl/uvs_sin.sv
`timescale 1ns / 1ps
module uvs_sin (
  input  logic                            clk,
  input  logic [uvs_pkg::SIN_STAGES-1:0]  ld,
  input  uvs_pkg::angle_t                 angle,
  output logic signed [15:0]              sin_q
);
  import uvs_pkg::*;

  localparam int HS = SIN_STAGES - 2;

  logic [30:0] x_r [SIN_STAGES-1];
  logic [30:0] u_r [SIN_STAGES-1];
  logic [30:0] t_r [SIN_STAGES-1];
  logic [1:0]  q_r [SIN_STAGES-1];
  logic signed [15:0] sin_r;

  logic [30:0] hc [HS];
  assign hc[0] = C7;
  assign hc[1] = C5;
  assign hc[2] = C3;
  assign hc[3] = C1;

  // quadrant fold and x squared
  logic [30:0] x_nxt;
  logic [61:0] xx;
  always_comb begin
    x_nxt = 31'({angle[ANGLE_BITS-3:0], (32 - ANGLE_BITS)'(0)});
    if (angle[ANGLE_BITS-2]) x_nxt = 31'(31'h4000_0000 - x_nxt);
    xx = 62'(x_nxt) * 62'(x_nxt);
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      x_r[0] <= x_nxt;
      u_r[0] <= xx[60:30];
      t_r[0] <= C9;
      q_r[0] <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
    end
  end

  // horner steps, one product per stage
  for (genvar k = 1; k <= HS; k++) begin : g_h
    logic [61:0] p;
    logic [30:0] t_nxt;
    assign p     = 62'(u_r[k-1]) * 62'(t_r[k-1]);
    assign t_nxt = 31'(hc[k-1] - p[60:30]);
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        x_r[k] <= x_r[k-1];
        u_r[k] <= u_r[k-1];
        t_r[k] <= t_nxt;
        q_r[k] <= q_r[k-1];
      end
    end
  end

  // final product, rounding, clamp and sign
  logic [61:0] s_p;
  logic [32:0] s_rnd;
  logic [15:0] v;
  logic signed [15:0] sin_nxt;
  always_comb begin
    s_p   = 62'(x_r[HS]) * 62'(t_r[HS]);
    s_rnd = 33'(s_p[61:30]) + 33'd32768;
    v     = (s_rnd[32:16] > 17'd16384) ? 16'd16384 : s_rnd[31:16];
    sin_nxt = q_r[HS][1] ? -$signed(v) : $signed(v);
  end

  always_ff @(posedge clk) begin
    if (ld[SIN_STAGES-1]) sin_r <= sin_nxt;
  end

  assign sin_q = sin_r;

endmodule

>>> hdl/uv_sphere_vertex_generator.sv
`timescale 1ns / 1ps
// UV sphere vertex generator: one corner of the sphere's triangle list per
// transaction. Fully pipelined: a new vertex number is taken every cycle while
// the output side does not stall. The path runs through the two 9-stage
// divider steps (strip/corner split, then the meridian and latitude angles)
// and the 6-stage sine polynomial. Stalls on the output fill empty slots
// first, so input is taken until the pipe is full.
// Registers sit at 0x0 (precision), 0x4 (radius, Q8.8) and 0x8 (RGBA color)
// and are to be written only while no transaction is in flight.
module uv_sphere_vertex_generator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [18:0]         in_vertex_number,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [16:0]  out_pos_x,
  output logic signed [16:0]  out_pos_y,
  output logic signed [16:0]  out_pos_z,
  output logic signed [15:0]  out_norm_x,
  output logic signed [15:0]  out_norm_y,
  output logic signed [15:0]  out_norm_z,
  output logic [31:0]         out_vertex_color,
  output logic                out_final_corner,
  output logic                out_out_of_range,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import uvs_pkg::*;

  cfg_t cfg;

  uvs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // stage valids and load enables
  logic [NS-1:0] v_r;
  logic [NS:0]   ld;
  meta_t         meta_r [NS];
  meta_t         meta_nxt0;
  meta_t         meta_nxt_dec;

  assign ld[NS]   = out_ready;
  assign in_ready = ld[0];

  for (genvar k = 0; k < NS; k++) begin : g_ctl
    assign ld[k] = ~v_r[k] | ld[k+1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ld[k]) begin
        v_r[k] <= (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        if (k == ST_IN) meta_r[k] <= meta_nxt0;
        else if (k == ST_DEC2) meta_r[k] <= meta_nxt_dec;
        else meta_r[k] <= meta_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // input stage: range check
  logic [18:0] idx_r;
  always_comb begin
    meta_nxt0          = '0;
    meta_nxt0.oor      = in_vertex_number >= cfg.total;
    meta_nxt0.fin      = in_vertex_number == 19'(cfg.total - 19'd1);
  end

  always_ff @(posedge clk) begin
    if (ld[ST_IN]) idx_r <= in_vertex_number;
  end

  // strip and corner split
  logic [DIV_QBITS-1:0] strip_q;
  logic [DIV_DBITS-1:0] corner;

  uvs_div u_div_strip (
    .clk (clk),
    .ld  (ld[ST_DIVA +: DIV_STAGES]),
    .num (DIV_NBITS'(idx_r)),
    .den (cfg.per),
    .quo (strip_q),
    .rem (corner)
  );

  // first decode: cap test and corner over six
  logic [7:0]  strip10_r;
  logic [10:0] c10_r;
  logic [10:0] c3_10_r;
  logic [7:0]  q6_10_r;
  logic        lo10_r;
  logic [10:0] c3_nxt;
  logic [26:0] q6_prod;

  assign c3_nxt  = 11'(corner - 11'd3);
  assign q6_prod = 27'(c3_nxt) * 27'(RECIP6);

  always_ff @(posedge clk) begin
    if (ld[ST_DEC1]) begin
      strip10_r <= strip_q[7:0];
      c10_r     <= corner;
      c3_10_r   <= c3_nxt;
      q6_10_r   <= q6_prod[25:18];
      lo10_r    <= corner < 11'd3;
    end
  end

  // second decode: meridian, ring and angle numerators
  logic [DIV_NBITS-1:0] phi_num_r, th_num_r;
  logic [DIV_DBITS-1:0] phi_den_r, th_den_r;
  logic [8:0]  m_nxt;
  logic [7:0]  r_nxt;
  logic [10:0] rem6_full;
  logic [2:0]  rem6;
  logic [10:0] ch;
  logic [9:0]  twice;
  logic [9:0]  mag;

  always_comb begin
    meta_nxt_dec = meta_r[ST_DEC1];
    rem6_full    = 11'(c3_10_r - 11'(q6_10_r) * 11'd6);
    rem6         = rem6_full[2:0];
    ch           = 11'(c3_10_r - 11'(cfg.per - 11'd6));
    m_nxt        = 9'(strip10_r);
    r_nxt        = 8'd0;
    if (lo10_r) begin
      if (c10_r == 11'd0) meta_nxt_dec.pole = 1'b1;
      else m_nxt = 9'(9'(strip10_r) + 9'(c10_r[1:0]) - 9'd1);
    end else if (c3_10_r < 11'(cfg.per - 11'd6)) begin
      m_nxt = 9'(9'(strip10_r) + 9'(rem6[0]));
      r_nxt = 8'(q6_10_r + ((rem6 == 3'd2 || rem6 == 3'd4 || rem6 == 3'd5) ? 8'd1 : 8'd0));
    end else begin
      if (ch == 11'd2) begin
        meta_nxt_dec.pole     = 1'b1;
        meta_nxt_dec.pole_top = 1'b1;
      end else begin
        m_nxt = 9'(9'(strip10_r) + 9'(ch[0]));
        r_nxt = 8'(cfg.p - 9'd2);
      end
    end
    twice = 10'((10'(r_nxt) + 10'd1) << 1);
    meta_nxt_dec.th_neg = twice < 10'(cfg.p);
    mag = meta_nxt_dec.th_neg ? 10'(10'(cfg.p) - twice) : 10'(twice - 10'(cfg.p));
  end

  always_ff @(posedge clk) begin
    if (ld[ST_DEC2]) begin
      phi_num_r <= DIV_NBITS'((DIV_NBITS'(m_nxt) << (ANGLE_BITS + 1)) + DIV_NBITS'(cfg.p));
      phi_den_r <= DIV_DBITS'(DIV_DBITS'(cfg.p) << 1);
      th_num_r  <= DIV_NBITS'((DIV_NBITS'(mag) << ANGLE_BITS)
                              + DIV_NBITS'(DIV_NBITS'(cfg.p) << 1));
      th_den_r  <= DIV_DBITS'(DIV_DBITS'(cfg.p) << 2);
    end
  end

  // angle dividers
  logic [DIV_QBITS-1:0] phi_q, th_q;
  logic [DIV_DBITS-1:0] phi_rem, th_rem;

  uvs_div u_div_phi (
    .clk (clk),
    .ld  (ld[ST_DIVB +: DIV_STAGES]),
    .num (phi_num_r),
    .den (phi_den_r),
    .quo (phi_q),
    .rem (phi_rem)
  );

  uvs_div u_div_theta (
    .clk (clk),
    .ld  (ld[ST_DIVB +: DIV_STAGES]),
    .num (th_num_r),
    .den (th_den_r),
    .quo (th_q),
    .rem (th_rem)
  );

  // angles, wrapped to a turn
  angle_t phi, theta, quarter;
  assign quarter = angle_t'(1) << (ANGLE_BITS - 2);
  assign phi     = phi_q[ANGLE_BITS-1:0];
  assign theta   = meta_r[ST_SIN-1].th_neg ? angle_t'(-th_q[ANGLE_BITS-1:0])
                                           : th_q[ANGLE_BITS-1:0];

  logic signed [15:0] ct, st, cp, sp;

  uvs_sin u_cos_t (.clk(clk), .ld(ld[ST_SIN +: SIN_STAGES]),
                   .angle(angle_t'(theta + quarter)), .sin_q(ct));
  uvs_sin u_sin_t (.clk(clk), .ld(ld[ST_SIN +: SIN_STAGES]),
                   .angle(theta), .sin_q(st));
  uvs_sin u_cos_p (.clk(clk), .ld(ld[ST_SIN +: SIN_STAGES]),
                   .angle(angle_t'(phi + quarter)), .sin_q(cp));
  uvs_sin u_sin_p (.clk(clk), .ld(ld[ST_SIN +: SIN_STAGES]),
                   .angle(phi), .sin_q(sp));

  // normal, poles overridden
  logic signed [15:0] nx_r, ny_r, nz_r;
  always_ff @(posedge clk) begin
    if (ld[ST_NRM]) begin
      if (meta_r[ST_NRM-1].pole) begin
        nx_r <= '0;
        ny_r <= meta_r[ST_NRM-1].pole_top ? 16'sd16384 : -16'sd16384;
        nz_r <= '0;
      end else begin
        nx_r <= mul_round14(ct, cp);
        ny_r <= st;
        nz_r <= mul_round14(ct, sp);
      end
    end
  end

  // position and output register
  always_ff @(posedge clk) begin
    if (ld[ST_POS]) begin
      if (meta_r[ST_POS-1].oor) begin
        out_pos_x  <= '0;
        out_pos_y  <= '0;
        out_pos_z  <= '0;
        out_norm_x <= '0;
        out_norm_y <= '0;
        out_norm_z <= '0;
      end else begin
        out_pos_x  <= mul_pos(nx_r, cfg.radius);
        out_pos_y  <= mul_pos(ny_r, cfg.radius);
        out_pos_z  <= mul_pos(nz_r, cfg.radius);
        out_norm_x <= nx_r;
        out_norm_y <= ny_r;
        out_norm_z <= nz_r;
      end
    end
  end

  assign out_valid        = v_r[ST_POS];
  assign out_out_of_range = meta_r[ST_POS].oor;
  assign out_final_corner = meta_r[ST_POS].fin & ~meta_r[ST_POS].oor;
  assign out_vertex_color = meta_r[ST_POS].oor ? 32'd0 : cfg.color;

  // remainders of the angle division and unused quotient high bits are not needed
  logic unused_rem;
  assign unused_rem = ^{phi_rem, th_rem, strip_q[DIV_QBITS-1:8], phi_q[DIV_QBITS-1],
                        th_q[DIV_QBITS-1]};

endmodule

>>> verif/uv_sphere_vertex_generator_tb.sv
`timescale 1ns / 1ps
module uv_sphere_vertex_generator_tb;
  import uvs_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = 60;

  typedef struct {
    logic signed [16:0] px, py, pz;
    logic signed [15:0] nx, ny, nz;
    logic [31:0]        col;
    logic               fin;
    logic               oor;
  } vertex_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [18:0]        in_vertex_number;
  logic               out_valid;
  logic               out_ready;
  logic signed [16:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [15:0] out_norm_x, out_norm_y, out_norm_z;
  logic [31:0]        out_vertex_color;
  logic               out_final_corner;
  logic               out_out_of_range;
  logic               psel, penable, pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  // testbench copy of the registers
  logic [8:0]  sh_prec;
  logic [15:0] sh_radius;
  logic [31:0] sh_color;

  logic [18:0] vnum_q[$];
  vertex_t     vertex_q[$];
  int          err_cnt;
  int          rx_count;
  int          cycle_cnt;
  int          gap_left;
  int          stall_left;
  int          hold_left;
  bit          hold_done;
  bit          no_idle;
  int          n_oor;
  int          n_pole;

  uv_sphere_vertex_generator uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_vertex_number(in_vertex_number),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_pos_x(out_pos_x), .out_pos_y(out_pos_y), .out_pos_z(out_pos_z),
    .out_norm_x(out_norm_x), .out_norm_y(out_norm_y), .out_norm_z(out_norm_z),
    .out_vertex_color(out_vertex_color), .out_final_corner(out_final_corner),
    .out_out_of_range(out_out_of_range),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sine of a turn fraction, q1.14, via truncated taylor series
  function automatic longint sine_q14(input longint ang);
    longint unsigned a, q, x, u, t, s, v;
    a = ang & 64'hFFFF;
    q = a >> 14;
    x = (a & 64'h3FFF) << 16;
    if (q[0]) x = (64'd1 << 30) - x;
    u = (x * x) >> 30;
    t = 64'(C9);
    t = 64'(C7) - ((u * t) >> 30);
    t = 64'(C5) - ((u * t) >> 30);
    t = 64'(C3) - ((u * t) >> 30);
    t = 64'(C1) - ((u * t) >> 30);
    s = (x * t) >> 30;
    v = (s + 64'd32768) >> 16;
    if (v > 64'd16384) v = 64'd16384;
    return (q >= 2) ? -longint'(v) : longint'(v);
  endfunction

  // product shifted by 14, magnitude rounded half up
  function automatic longint scale14(input longint a, input longint b);
    longint ma, mb, p;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p  = (ma * mb + 8192) >>> 14;
    return ((a < 0) != (b < 0)) ? -p : p;
  endfunction

  // expected corner for a vertex number under the current registers
  function automatic vertex_t corner_of(input logic [18:0] vn);
    vertex_t e;
    longint p, per, total, idx, strip, c, m, r, pole, rad;
    longint phi, twice, mag, a, theta, ct, st, cp, sp, n0, n1, n2;
    e = '{default: '0};
    p = sh_prec;
    if (p < 2) p = 2;
    if (p > MAX_PRECISION) p = MAX_PRECISION;
    per   = 6 * p - 6;
    total = p * per;
    idx   = vn;
    if (idx >= total) begin
      e.oor = 1'b1;
      return e;
    end
    strip = idx / per;
    c     = idx % per;
    m     = strip;
    r     = 0;
    pole  = 0;
    if (c < 3) begin
      if (c == 0) pole = -1;
      else m = strip + c - 1;
    end else begin
      c = c - 3;
      if (c < 6 * (p - 2)) begin
        m = strip + ((c % 6) & 1);
        r = c / 6 + (((c % 6) == 2 || (c % 6) >= 4) ? 1 : 0);
      end else begin
        c = c - 6 * (p - 2);
        if (c == 2) pole = 1;
        else begin
          m = strip + c;
          r = p - 2;
        end
      end
    end
    rad = sh_radius;
    if (pole != 0) begin
      n0 = 0;
      n1 = pole * 16384;
      n2 = 0;
      e.py = 17'(pole * rad);
    end else begin
      phi   = (((m << 16) * 2 + p) / (2 * p)) & 64'hFFFF;
      twice = 2 * (r + 1);
      mag   = (twice >= p) ? twice - p : p - twice;
      a     = ((mag << 16) + 2 * p) / (4 * p);
      theta = ((twice >= p) ? a : (65536 - a)) & 64'hFFFF;
      ct = sine_q14(theta + 16384);
      st = sine_q14(theta);
      cp = sine_q14(phi + 16384);
      sp = sine_q14(phi);
      n0 = scale14(ct, cp);
      n1 = st;
      n2 = scale14(ct, sp);
      e.px = 17'(scale14(n0, rad));
      e.py = 17'(scale14(n1, rad));
      e.pz = 17'(scale14(n2, rad));
    end
    e.nx  = 16'(n0);
    e.ny  = 16'(n1);
    e.nz  = 16'(n2);
    e.col = sh_color;
    e.fin = (idx == total - 1);
    return e;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, rx_count);
    err_cnt++;
  endtask

  function automatic int pick_wait();
    int k;
    if (no_idle) return 0;
    k = $urandom_range(0, 99);
    if (k < 70) return 0;
    if (k < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: next vertex number once the current one is taken
  always @(posedge clk) begin
    if (in_valid && !in_ready) begin
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (vnum_q.size() > 0) begin
      in_valid         <= 1'b1;
      in_vertex_number <= vnum_q.pop_front();
      gap_left         <= pick_wait();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // receiver ready, with one long hold-off to back the pipe up
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && rx_count >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready  <= 1'b1;
      stall_left <= pick_wait();
    end
  end

  // monitor: predict on input transaction, check on output transaction
  always @(posedge clk) begin
    vertex_t e;
    if (rst_n && in_valid && in_ready) begin
      e = corner_of(in_vertex_number);
      if (e.oor) n_oor++;
      if (!e.oor && e.nx == 0 && e.nz == 0 && (e.ny == 16384 || e.ny == -16384)) n_pole++;
      vertex_q.insert(vertex_q.size(), e);
    end
    if (rst_n && out_valid && out_ready) begin
      if (vertex_q.size() == 0) begin
        report("unexpected result transaction", 1, 0);
      end else begin
        e = vertex_q.pop_front();
        if (out_pos_x !== e.px) report("pos_x", out_pos_x, e.px);
        if (out_pos_y !== e.py) report("pos_y", out_pos_y, e.py);
        if (out_pos_z !== e.pz) report("pos_z", out_pos_z, e.pz);
        if (out_norm_x !== e.nx) report("norm_x", out_norm_x, e.nx);
        if (out_norm_y !== e.ny) report("norm_y", out_norm_y, e.ny);
        if (out_norm_z !== e.nz) report("norm_z", out_norm_z, e.nz);
        if (out_vertex_color !== e.col) report("vertex_color", out_vertex_color, e.col);
        if (out_final_corner !== e.fin) report("final_corner", out_final_corner, e.fin);
        if (out_out_of_range !== e.oor) report("out_of_range", out_out_of_range, e.oor);
      end
      rx_count++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PRECISION: sh_prec = val[8:0];
      REG_RADIUS:    sh_radius = val[15:0];
      REG_COLOR:     sh_color = val;
      default: begin
      end
    endcase
  endtask

  task automatic wait_drained();
    while (vnum_q.size() > 0 || in_valid || vertex_q.size() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // random vertex numbers, mostly inside the list
  task automatic load_random(input int count);
    int p, total;
    p = sh_prec;
    if (p < 2) p = 2;
    if (p > MAX_PRECISION) p = MAX_PRECISION;
    total = p * (6 * p - 6);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) == 0) vnum_q.insert(vnum_q.size(), 19'($urandom));
      else vnum_q.insert(vnum_q.size(), 19'($urandom_range(0, total - 1)));
    end
  endtask

  initial begin
    int prec_set[8];
    rst_n = 1'b0; in_valid = 1'b0; in_vertex_number = '0; out_ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    gap_left = 0; stall_left = 0; hold_left = 0; hold_done = 0; no_idle = 0;
    err_cnt = 0; rx_count = 0; cycle_cnt = 0; n_oor = 0; n_pole = 0;
    sh_prec = 9'd16; sh_radius = 16'd256; sh_color = 32'hFFFFFFFF;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed at reset values: poles, ring corners, seam, last corner, past end
    foreach (prec_set[i]) prec_set[i] = 0;
    vnum_q = '{19'd0, 19'd1, 19'd2, 19'd3, 19'd4, 19'd5, 19'd6, 19'd7, 19'd8,
               19'd87, 19'd88, 19'd89, 19'd90, 19'd1350, 19'd1351, 19'd1352,
               19'd1437, 19'd1438, 19'd1439, 19'd1440, 19'd524287, 19'd262144};
    wait_drained();

    prec_set = '{2, 256, 0, 511, 1, 3, 7, 33};
    for (int ph = 0; ph < 8; ph++) begin
      reg_write(REG_PRECISION, prec_set[ph]);
      case (ph)
        0: reg_write(REG_RADIUS, 32'd0);
        1: reg_write(REG_RADIUS, 32'd65535);
        default: reg_write(REG_RADIUS, $urandom_range(0, 65535));
      endcase
      case (ph)
        0: reg_write(REG_COLOR, 32'h0);
        1: reg_write(REG_COLOR, 32'hFFFFFFFF);
        default: reg_write(REG_COLOR, $urandom);
      endcase
      no_idle = (ph == 3);
      if (ph == 0) vnum_q = '{19'd0, 19'd5, 19'd6, 19'd11, 19'd12, 19'd524287};
      if (ph == 1) vnum_q = '{19'd391679, 19'd391680, 19'd0, 19'd1529};
      load_random(220);
      wait_drained();
    end

    $display("covered %0d corners over 9 register settings, %0d past the end, %0d poles",
             rx_count, n_oor, n_pole);
    $display("precision 0..511 incl. clamps, radius 0 and 65535, long output hold-off");
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/uvs_pkg.sv
hdl/uvs_cfg.sv
hdl/uvs_div.sv
hdl/uvs_sin.sv
hdl/uv_sphere_vertex_generator.sv
verif/uv_sphere_vertex_generator_tb.sv
